>>> rtl/core/swa_pkg.sv
// shared constants, codes and types of the sliding window arq sender
package swa_pkg;

	localparam int MAX_PACKETS = 1024;
	localparam int MAX_WINDOW  = 32;

	localparam int SEQ_W      = $clog2(MAX_PACKETS);
	localparam int CNT_W      = $clog2(MAX_PACKETS) + 1;
	localparam int WIN_W      = $clog2(MAX_WINDOW + 1);
	localparam int MAP_IDX_W  = $clog2(MAX_WINDOW);
	localparam int CMD_W      = 2;
	localparam int KIND_W     = 3;
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = CNT_W;

	// operating modes, the unused code behaves as stop-and-wait
	localparam logic [MODE_W-1:0] MODE_SAW = 2'd0;
	localparam logic [MODE_W-1:0] MODE_GBN = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SR  = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL  = 2'd2;

	typedef enum logic [CMD_W-1:0] {
		CMD_SEND    = 2'd0,
		CMD_ACK     = 2'd1,
		CMD_TIMEOUT = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_NEW         = 3'd0,
		KIND_REFUSED     = 3'd1,
		KIND_RETX        = 3'd2,
		KIND_NOTHING_DUE = 3'd3,
		KIND_ACK_TAKEN   = 3'd4,
		KIND_ACK_IGNORED = 3'd5,
		KIND_ACK_RANGE   = 3'd6
	} kind_t;

	typedef struct packed {
		cmd_t             cmd;
		logic [SEQ_W-1:0] ack;
	} op_t;

	typedef struct packed {
		logic valid;
		op_t  op;
	} q_head_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [WIN_W-1:0]  win;
		logic [CNT_W-1:0]  total;
	} cfg_eff_t;

endpackage

>>> rtl/core/swa_if.sv
// handshake channels of the sliding window arq sender

interface swa_req_if;
	logic                       valid;
	logic                       ready;
	logic [swa_pkg::CMD_W-1:0]  command;
	logic [swa_pkg::SEQ_W-1:0]  ack_number;

	modport source (output valid, command, ack_number, input ready);
	modport sink (input valid, command, ack_number, output ready);
endinterface

interface swa_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [swa_pkg::KIND_W-1:0] kind;
	logic [swa_pkg::SEQ_W-1:0]  seq_number;
	logic [swa_pkg::CNT_W-1:0]  window_base;
	logic                       all_done;
	logic                       last;

	modport source (output valid, kind, seq_number, window_base, all_done, last, input ready);
	modport sink (input valid, kind, seq_number, window_base, all_done, last, output ready);
endinterface

interface swa_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [swa_pkg::CFG_IDX_W-1:0]   index;
	logic [swa_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/swa_front.sv
// front end: command decode and two-entry command queue
module swa_front (
	input  logic              clk,
	input  logic              arst_n,
	swa_req_if.sink           req,
	input  logic              pop,
	output swa_pkg::q_head_t  head
);

	swa_pkg::op_t ent_q [2];
	logic         wr_q;
	logic         rd_q;
	logic [1:0]   cnt_q;
	logic         accept;
	logic         push;
	swa_pkg::op_t op_in;

	assign req.ready = (cnt_q != 2'd2);
	assign accept    = req.valid && req.ready;
	assign op_in.cmd = swa_pkg::cmd_t'(req.command);
	assign op_in.ack = req.ack_number;
	// unknown command is taken and dropped, it has no result
	assign push      = accept && (op_in.cmd != swa_pkg::CMD_NONE);

	assign head.valid = (cnt_q != 2'd0);
	assign head.op    = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= op_in;
		end
	end

endmodule

>>> rtl/core/swa_back.sv
// back end: window state, acknowledged map, base advance and timeout scan
module swa_back (
	input  logic              clk,
	input  logic              arst_n,
	input  swa_pkg::cfg_eff_t cfg_eff,
	input  swa_pkg::q_head_t  head,
	output logic              pop,
	swa_rsp_if.source         rsp
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ADV,
		ST_SCAN
	} state_t;

	state_t                            state_q;
	logic [swa_pkg::CNT_W-1:0]         base_q;
	logic [swa_pkg::CNT_W-1:0]         next_q;
	// bit k stands for sequence number base_q + k
	logic [swa_pkg::MAX_WINDOW-1:0]    map_q;
	logic [swa_pkg::MAX_WINDOW-1:0]    scan_q;
	logic [swa_pkg::SEQ_W-1:0]         idx_q;

	logic                              rsp_valid_q;
	swa_pkg::kind_t                    rsp_kind_q;
	logic [swa_pkg::SEQ_W-1:0]         rsp_seq_q;
	logic [swa_pkg::CNT_W-1:0]         rsp_base_q;
	logic                              rsp_done_q;
	logic                              rsp_last_q;

	logic                              out_free;
	logic [swa_pkg::CNT_W-1:0]         ack_ext;
	logic [swa_pkg::CNT_W-1:0]         ack_diff;
	logic [swa_pkg::MAP_IDX_W-1:0]     ack_rel;
	logic                              ack_above;
	logic                              ack_bad;
	logic                              ack_take;
	logic                              send_ok;
	logic [swa_pkg::CNT_W-1:0]         span;
	logic [swa_pkg::CNT_W-1:0]         gap_tot;
	logic [swa_pkg::CNT_W-1:0]         len_c;
	logic [swa_pkg::WIN_W-1:0]         len;
	logic [swa_pkg::MAX_WINDOW-1:0]    range_mask;
	logic [swa_pkg::MAX_WINDOW-1:0]    miss;
	logic                              adv_go;
	logic                              done_now;
	logic                              scan_last;
	logic                              rsp_set;

	assign out_free = !rsp_valid_q || rsp.ready;
	assign pop      = (state_q == ST_IDLE) && head.valid && out_free;

	always_comb begin
		ack_ext   = {{(swa_pkg::CNT_W - swa_pkg::SEQ_W){1'b0}}, head.op.ack};
		ack_diff  = ack_ext - base_q;
		ack_rel   = ack_diff[swa_pkg::MAP_IDX_W-1:0];
		ack_above = (ack_ext >= base_q);
		ack_bad   = (ack_ext >= next_q) || (ack_ext >= cfg_eff.total);
		case (cfg_eff.mode)
			swa_pkg::MODE_GBN: ack_take = ack_above;
			swa_pkg::MODE_SR:  ack_take = 1'b1;
			default:           ack_take = (ack_ext == base_q);
		endcase

		send_ok = ({1'b0, next_q} <
			({1'b0, base_q} + {{(swa_pkg::CNT_W + 1 - swa_pkg::WIN_W){1'b0}}, cfg_eff.win}))
			&& (next_q < cfg_eff.total);

		// scan length is min(window, outstanding, packets left)
		span    = next_q - base_q;
		gap_tot = (cfg_eff.total > base_q) ? (cfg_eff.total - base_q) : '0;
		len_c   = {{(swa_pkg::CNT_W - swa_pkg::WIN_W){1'b0}}, cfg_eff.win};
		if (span < len_c) begin
			len_c = span;
		end
		if (gap_tot < len_c) begin
			len_c = gap_tot;
		end
		len = len_c[swa_pkg::WIN_W-1:0];
		for (int k = 0; k < swa_pkg::MAX_WINDOW; k++) begin
			range_mask[k] = (swa_pkg::WIN_W'(k) < len);
		end
		miss = ~map_q & range_mask;

		adv_go    = (base_q < cfg_eff.total) && map_q[0];
		done_now  = (base_q >= cfg_eff.total);
		scan_last = (scan_q[swa_pkg::MAX_WINDOW-1:1] == '0);

		// a new result is loaded this cycle, always with the output register free
		rsp_set = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (pop) begin
					case (head.op.cmd)
						swa_pkg::CMD_SEND:    rsp_set = 1'b1;
						swa_pkg::CMD_ACK:     rsp_set = ack_bad || !ack_take;
						swa_pkg::CMD_TIMEOUT: rsp_set = (miss == '0);
						default:              rsp_set = 1'b0;
					endcase
				end
			end
			ST_ADV:  rsp_set = !adv_go && out_free;
			ST_SCAN: rsp_set = scan_q[0] && out_free;
			default: rsp_set = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			base_q      <= '0;
			next_q      <= '0;
			map_q       <= '0;
			scan_q      <= '0;
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				rsp_valid_q <= rsp_set;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						case (head.op.cmd)
							swa_pkg::CMD_SEND: begin
								rsp_base_q  <= base_q;
								rsp_done_q  <= done_now;
								rsp_last_q  <= 1'b1;
								if (send_ok) begin
									next_q     <= next_q + 1'b1;
									rsp_kind_q <= swa_pkg::KIND_NEW;
									rsp_seq_q  <= next_q[swa_pkg::SEQ_W-1:0];
								end else begin
									rsp_kind_q <= swa_pkg::KIND_REFUSED;
									rsp_seq_q  <= '0;
								end
							end
							swa_pkg::CMD_ACK: begin
								if (ack_bad || !ack_take) begin
									rsp_kind_q  <= ack_bad ? swa_pkg::KIND_ACK_RANGE
										: swa_pkg::KIND_ACK_IGNORED;
									rsp_seq_q   <= '0;
									rsp_base_q  <= base_q;
									rsp_done_q  <= done_now;
									rsp_last_q  <= 1'b1;
								end else begin
									// numbers below the base already count as acknowledged
									if (ack_above) begin
										map_q[ack_rel] <= 1'b1;
									end
									state_q <= ST_ADV;
								end
							end
							swa_pkg::CMD_TIMEOUT: begin
								if (miss == '0) begin
									rsp_kind_q  <= swa_pkg::KIND_NOTHING_DUE;
									rsp_seq_q   <= '0;
									rsp_base_q  <= base_q;
									rsp_done_q  <= done_now;
									rsp_last_q  <= 1'b1;
								end else begin
									scan_q  <= miss;
									idx_q   <= base_q[swa_pkg::SEQ_W-1:0];
									state_q <= ST_SCAN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_ADV: begin
					if (adv_go) begin
						base_q <= base_q + 1'b1;
						map_q  <= map_q >> 1;
					end else if (out_free) begin
						rsp_kind_q  <= swa_pkg::KIND_ACK_TAKEN;
						rsp_seq_q   <= '0;
						rsp_base_q  <= base_q;
						rsp_done_q  <= done_now;
						rsp_last_q  <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (!scan_q[0]) begin
						scan_q <= scan_q >> 1;
						idx_q  <= idx_q + 1'b1;
					end else if (out_free) begin
						rsp_kind_q  <= swa_pkg::KIND_RETX;
						rsp_seq_q   <= idx_q;
						rsp_base_q  <= base_q;
						rsp_done_q  <= done_now;
						rsp_last_q  <= scan_last;
						scan_q      <= scan_q >> 1;
						idx_q       <= idx_q + 1'b1;
						if (scan_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.kind        = rsp_kind_q;
	assign rsp.seq_number  = rsp_seq_q;
	assign rsp.window_base = rsp_base_q;
	assign rsp.all_done    = rsp_done_q;
	assign rsp.last        = rsp_last_q;

	// outstanding numbers always fit the acknowledged map
	a_window_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(base_q <= next_q) && ((next_q - base_q) <= swa_pkg::CNT_W'(swa_pkg::MAX_WINDOW)))
		else $error("outstanding span exceeds the map");

	// a scan always has at least one retransmission left
	a_scan_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (scan_q != '0))
		else $error("scan running with nothing left to send");

	// the base never moves backwards
	a_base_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (base_q >= $past(base_q)))
		else $error("window base went backwards");

	// commands are taken from the queue only when one is there
	a_pop_head: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (head.valid && (state_q == ST_IDLE)))
		else $error("pop from an empty queue");

endmodule

>>> rtl/core/sliding_window_arq_sender_unit.sv
// top level of the sliding window arq sender: registers, front end and back end
//
// Sender-side window tracker for an ARQ link in stop-and-wait, go-back-N or
// selective repeat mode. Commands (send, ack, timeout) arrive as transactions
// on req and each produces one or more result transactions on rsp, in order,
// with last set on the final one. The front end takes a command per cycle
// while its two-entry queue has room, so input keeps flowing while a result
// waits on rsp until the queue fills. A send or a refused/out-of-range ack
// goes from the queue to the registered result, one command per cycle while
// rsp is not stalled. A taken ack marks its number in the map, then the base
// slides over each acknowledged number (up to the window, 32) before the
// result. A timeout walks the positions up to the last unacknowledged one,
// at most 32, in the shift register of pending numbers, one retransmission
// each, taking no new command until the walk ends. Only the outstanding
// window is kept in the acknowledged map (numbers below the base count as
// acknowledged, numbers not yet sent as not), so there is no clearing pass
// after reset. The configuration port is always ready and should be written
// only while the block is idle; writes to an unknown index are ignored.
module sliding_window_arq_sender_unit (
	input  logic     clk,
	input  logic     arst_n,
	swa_req_if.sink  req,
	swa_rsp_if.source rsp,
	swa_cfg_if.sink  cfg
);

	// configuration registers as written
	logic [swa_pkg::MODE_W-1:0] mode_q;
	logic [swa_pkg::WIN_W-1:0]  window_q;
	logic [swa_pkg::CNT_W-1:0]  total_q;

	swa_pkg::cfg_eff_t cfg_eff;
	swa_pkg::q_head_t  head;
	logic              pop;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= swa_pkg::MODE_SAW;
			window_q <= swa_pkg::WIN_W'(1);
			total_q  <= swa_pkg::CNT_W'(1);
		end else if (cfg.valid) begin
			case (cfg.index)
				swa_pkg::REG_MODE:   mode_q   <= cfg.data[swa_pkg::MODE_W-1:0];
				swa_pkg::REG_WINDOW: window_q <= cfg.data[swa_pkg::WIN_W-1:0];
				swa_pkg::REG_TOTAL:  total_q  <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// effective values: stop-and-wait forces a window of one, zero counts as
	// one and anything above the limits is clamped
	always_comb begin
		cfg_eff.mode = mode_q;
		if ((mode_q != swa_pkg::MODE_GBN && mode_q != swa_pkg::MODE_SR) || window_q == '0) begin
			cfg_eff.win = swa_pkg::WIN_W'(1);
		end else if (window_q > swa_pkg::WIN_W'(swa_pkg::MAX_WINDOW)) begin
			cfg_eff.win = swa_pkg::WIN_W'(swa_pkg::MAX_WINDOW);
		end else begin
			cfg_eff.win = window_q;
		end
		if (total_q == '0) begin
			cfg_eff.total = swa_pkg::CNT_W'(1);
		end else if (total_q > swa_pkg::CNT_W'(swa_pkg::MAX_PACKETS)) begin
			cfg_eff.total = swa_pkg::CNT_W'(swa_pkg::MAX_PACKETS);
		end else begin
			cfg_eff.total = total_q;
		end
	end

	// front end: decode and queue
	swa_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.pop    (pop),
		.head   (head)
	);

	// back end: window bookkeeping and result generation
	swa_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_eff (cfg_eff),
		.head    (head),
		.pop     (pop),
		.rsp     (rsp)
	);

endmodule
